>>> rtl/cte_pkg.sv
`timescale 1ns / 1ps

package cte_pkg;

  // field widths of one tick item
  localparam int unsigned UnixW   = 32;
  localparam int unsigned SecW    = 6;
  localparam int unsigned MinW    = 6;
  localparam int unsigned HourW   = 5;
  localparam int unsigned WdayW   = 3;
  localparam int unsigned MdayW   = 5;
  localparam int unsigned MonW    = 4;
  localparam int unsigned OfsW    = 11;
  localparam int unsigned TolW    = 16;
  localparam int unsigned FlagW   = 13;

  // stream and config port widths
  localparam int unsigned InDataW  = 128;
  localparam int unsigned OutDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [HourW-1:0] MiddayHour = HourW'(12);
  localparam logic [TolW-1:0]  TolReset   = TolW'(60);

  // event flag bit positions
  localparam int unsigned EvSec    = 0;
  localparam int unsigned EvMin    = 1;
  localparam int unsigned EvHour   = 2;
  localparam int unsigned EvMidday = 3;
  localparam int unsigned EvDay    = 4;
  localparam int unsigned EvWeek   = 5;
  localparam int unsigned EvMonth  = 6;
  localparam int unsigned EvYear   = 7;
  localparam int unsigned EvDstOn  = 8;
  localparam int unsigned EvDstOff = 9;
  localparam int unsigned EvDawn   = 10;
  localparam int unsigned EvDusk   = 11;
  localparam int unsigned EvResync = 12;

  typedef enum logic [1:0] {
    SunNight   = 2'd0,
    SunDay     = 2'd1,
    SunUnknown = 2'd2
  } sun_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgResyncEn  = 3'd0,
    CfgResyncTol = 3'd1,
    CfgEventMask = 3'd2,
    CfgDawnOfs   = 3'd3,
    CfgDuskOfs   = 3'd4
  } cfg_idx_e;

  // one tick item, last member in the lowest bits
  typedef struct packed {
    logic [UnixW-1:0] dusk_time;
    logic [UnixW-1:0] dawn_time;
    logic             dst_active;
    logic [MonW-1:0]  month;
    logic [MdayW-1:0] day_of_month;
    logic [WdayW-1:0] weekday;
    logic [HourW-1:0] hour;
    logic [MinW-1:0]  minute;
    logic [SecW-1:0]  second;
    logic [UnixW-1:0] unix_time;
  } tick_t;

  localparam int unsigned TickW = $bits(tick_t);

  // signed minutes to signed seconds, wrapped to 32 bits
  function automatic logic [UnixW-1:0] min_to_sec(input logic signed [OfsW-1:0] ofs);
    logic [UnixW-1:0] x;
    x = UnixW'(signed'(ofs));
    return (x << 6) - (x << 2);
  endfunction

endpackage

>>> rtl/calendar_tick_event_flags_core.sv
`timescale 1ns / 1ps

// calendar tick event flags
// slave stream takes one tick item per second of wall time: unix time,
// broken-down local time, dst bit and today's dawn and dusk instants.
// master stream returns one item per tick: a 13-bit event mask, the
// daytime bit and notify (events overlapping the configured mask).
// config channel writes registers by index; it is always ready. The user
// must write it only while no tick is in flight; the block does not
// enforce this. The tick is captured in the input register at the accept,
// then the result in the result register; one tick accepted every cycle
// while the master side takes results; the drift check, calendar compares
// and dawn/dusk trigger compares sit in one stage.
// a stalled master side holds the result; a new tick still enters the
// input register and waits there, so the slave side stalls one item later.
// reset clears the registers to their defaults, the time shadow and dst
// history to zero and the sun state to day.
module calendar_tick_event_flags_core
  import cte_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // tick input
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // unix_time, second, minute, hour, weekday, day_of_month, month,
  // dst_active, dawn_time, dusk_time, zero pad
  input  logic [InDataW-1:0]  s_axis_tdata,
  // event output
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // event_flags, daytime, notify, zero pad
  output logic [OutDataW-1:0] m_axis_tdata,
  // register writes
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);

  // configuration registers
  logic                   resync_en_q;
  logic [TolW-1:0]        resync_tol_q;
  logic [FlagW-1:0]       event_mask_q;
  logic signed [OfsW-1:0] dawn_ofs_q;
  logic signed [OfsW-1:0] dusk_ofs_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      resync_en_q  <= 1'b0;
      resync_tol_q <= TolReset;
      event_mask_q <= '0;
      dawn_ofs_q   <= '0;
      dusk_ofs_q   <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgResyncEn:  resync_en_q  <= cfg_data_i[0];
        CfgResyncTol: resync_tol_q <= cfg_data_i[TolW-1:0];
        CfgEventMask: event_mask_q <= cfg_data_i[FlagW-1:0];
        CfgDawnOfs:   dawn_ofs_q   <= signed'(cfg_data_i[OfsW-1:0]);
        CfgDuskOfs:   dusk_ofs_q   <= signed'(cfg_data_i[OfsW-1:0]);
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // handshake between input register and result register
  logic  in_vld_q;
  tick_t tick_q;
  logic  out_vld_q;
  logic  advance;

  assign advance       = in_vld_q && (!out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (advance) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      tick_q <= tick_t'(s_axis_tdata[TickW-1:0]);
    end
  end

  // block state carried from tick to tick
  logic [UnixW-1:0] shadow_q, shadow_d;
  logic             dst_seen_q;
  sun_state_e       sun_q, sun_d;

  // exact signed drift; shadow counts ticks, wraps, reloads on resync or off
  logic [UnixW-1:0] shadow_inc;
  logic [UnixW+1:0] drift;
  logic [UnixW+1:0] drift_mag;
  logic             resync;

  always_comb begin
    shadow_inc = shadow_q + UnixW'(1);
    drift      = {2'b00, shadow_inc} - {2'b00, tick_q.unix_time};
    drift_mag  = drift[UnixW+1] ? -drift : drift;
    resync     = resync_en_q && (drift_mag > (UnixW+2)'(resync_tol_q));
    if (!resync_en_q || resync) begin
      shadow_d = tick_q.unix_time;
    end else begin
      shadow_d = shadow_inc;
    end
  end

  // calendar events, each nested under the coarser one
  logic ev_min, ev_hour, ev_day;
  logic [UnixW-1:0] dawn_trig, dusk_trig;
  logic             after_dawn, before_dusk, after_dusk;
  sun_state_e       sun_mid;
  logic [FlagW-1:0] flags;

  always_comb begin
    ev_min  = (tick_q.second == '0);
    ev_hour = ev_min && (tick_q.minute == '0);
    ev_day  = ev_hour && (tick_q.hour == '0);

    // midnight forgets which side of the sun we are on
    sun_mid = ev_day ? SunUnknown : sun_q;

    dawn_trig   = tick_q.dawn_time + min_to_sec(dawn_ofs_q);
    dusk_trig   = tick_q.dusk_time + min_to_sec(dusk_ofs_q);
    after_dawn  = tick_q.unix_time > dawn_trig;
    before_dusk = tick_q.unix_time < dusk_trig;
    after_dusk  = tick_q.unix_time > dusk_trig;

    flags            = '0;
    flags[EvSec]     = 1'b1;
    flags[EvMin]     = ev_min;
    flags[EvHour]    = ev_hour;
    flags[EvMidday]  = ev_hour && (tick_q.hour == MiddayHour);
    flags[EvDay]     = ev_day;
    flags[EvWeek]    = ev_day && (tick_q.weekday == WdayW'(1));
    flags[EvMonth]   = ev_day && (tick_q.day_of_month == MdayW'(1));
    flags[EvYear]    = flags[EvMonth] && (tick_q.month == '0);
    // a resync suppresses the dst edge events, so no dst edge is seen
    flags[EvDstOn]   = !resync && !dst_seen_q && tick_q.dst_active;
    flags[EvDstOff]  = !resync && dst_seen_q && !tick_q.dst_active;
    flags[EvResync]  = resync;

    sun_d = sun_mid;
    if ((sun_mid == SunNight || sun_mid == SunUnknown) && after_dawn && before_dusk) begin
      flags[EvDawn] = 1'b1;
      sun_d         = SunDay;
    end else if (sun_mid != SunNight && after_dusk) begin
      flags[EvDusk] = 1'b1;
      sun_d         = SunNight;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_q   <= '0;
      dst_seen_q <= 1'b0;
      sun_q      <= SunDay;
    end else if (advance) begin
      shadow_q   <= shadow_d;
      // dst history always ends up equal to the tick's dst bit
      dst_seen_q <= tick_q.dst_active;
      sun_q      <= sun_d;
    end
  end

  // result register
  logic [FlagW-1:0] flags_q;
  logic             daytime_q;
  logic             notify_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      flags_q   <= flags;
      daytime_q <= (sun_d == SunDay);
      notify_q  <= |(flags & event_mask_q);
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {(OutDataW - FlagW - 2)'(0), notify_q, daytime_q, flags_q};

`ifndef SYNTHESIS
  // every tick raises the second event
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> flags_q[EvSec])
    else $error("second event missing");

  // dst on and off exclude each other and never come with a resync
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(flags_q[EvDstOn] && flags_q[EvDstOff]) &&
                  !(flags_q[EvResync] && (flags_q[EvDstOn] || flags_q[EvDstOff])))
    else $error("inconsistent dst events");

  // dawn and dusk are exclusive and agree with the daytime bit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(flags_q[EvDawn] && flags_q[EvDusk]) &&
                  (!flags_q[EvDawn] || daytime_q) && (!flags_q[EvDusk] || !daytime_q))
    else $error("sun events disagree with daytime");

  // a result held under stall keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !m_axis_tready |=> out_vld_q && $stable(flags_q) && $stable(notify_q))
    else $error("stalled result changed");
`endif

endmodule
